/* hdl/wall_ring_chainer_macros.svh */
// ----------------------------------------------------------------------------
// wall_ring_chainer_macros.svh
// Assertion macros for the wall ring chainer (clk / rst_n in scope).
// ----------------------------------------------------------------------------
`ifndef WALL_RING_CHAINER_MACROS_SVH
`define WALL_RING_CHAINER_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define WRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked during reset too
`define WRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WRC_ASSERT(lbl, prop, msg)
`define WRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hdl/wrc_pkg.sv */
// ----------------------------------------------------------------------------
// wrc_pkg
// Types, constants and helpers shared by the wall ring chainer.
// ----------------------------------------------------------------------------
package wrc_pkg;

  localparam int MAX_WALLS = 64;
  localparam int AW = $clog2(MAX_WALLS);
  localparam int CW = $clog2(MAX_WALLS + 1);

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_REV  = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // memory read address source
  localparam logic [1:0] RD_ZERO = 2'd0;
  localparam logic [1:0] RD_J    = 2'd1;
  localparam logic [1:0] RD_JM1  = 2'd2;
  localparam logic [1:0] RD_CUR  = 2'd3;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
  } wall_t;

  typedef struct packed {
    logic       latch_in;
    logic       do_add;
    logic       rd_en;
    logic [1:0] rd_src;
    logic       set_p;
    logic       init_j;
    logic       inc_j;
    logic       take_match;
    logic       wr_shift;
    logic       wr_put;
    logic       next_i;
    logic       step_cur;
    logic       flip_dir;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       i_lt_cnt;
    logic       j_lt_cnt;
    logic       j_gt_i1;
    logic       match;
  } dp_stat_t;

  function automatic logic near(logic signed [31:0] a, logic signed [31:0] b,
                                logic [30:0] tol);
    logic signed [32:0] d;
    logic [32:0]        ad;
    d  = 33'(a) - 33'(b);
    ad = d[32] ? 33'(-d) : 33'(d);
    return ad <= {2'b00, tol};
  endfunction

endpackage

/* hdl/wall_ring_chainer.sv */
// ----------------------------------------------------------------------------
// wall_ring_chainer
// Wall store kept chained into a ring, with a cursor and a bounding box.
// ----------------------------------------------------------------------------
// Read, step, reverse and a dropped add read the wall at the cursor into the result; step
// moves the cursor once, reverse flips the direction and moves it twice. Add stores the
// wall, then re-chains the store: each wall touching the chain point is moved up after it.
// Throughput: one item at a time; the next is taken the cycle after the result is
// loaded into the output register, and a stalled result holds the sequencer.
// Reset (rst_n, synchronous): empty store, cursor 0, backward, tolerance 66, box inverted.
module wall_ring_chainer import wrc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [30:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_from_x,
  input  logic signed [31:0] in_from_y,
  input  logic signed [31:0] in_to_x,
  input  logic signed [31:0] in_to_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_cur_from_x,
  output logic signed [31:0] out_cur_from_y,
  output logic signed [31:0] out_cur_to_x,
  output logic signed [31:0] out_cur_to_y,
  output logic [5:0]         out_cursor_pos,
  output logic [6:0]         out_wall_total,
  output logic signed [31:0] out_box_min_x,
  output logic signed [31:0] out_box_min_y,
  output logic signed [31:0] out_box_max_x,
  output logic signed [31:0] out_box_max_y,
  output logic [1:0]         out_status
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       add_full;
  logic [1:0] dp_status;

  wrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .add_full  (add_full)
  );

  wrc_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_cmd         (in_cmd),
    .in_from_x      (in_from_x),
    .in_from_y      (in_from_y),
    .in_to_x        (in_to_x),
    .in_to_y        (in_to_y),
    .out_cur_from_x (out_cur_from_x),
    .out_cur_from_y (out_cur_from_y),
    .out_cur_to_x   (out_cur_to_x),
    .out_cur_to_y   (out_cur_to_y),
    .out_cursor_pos (out_cursor_pos),
    .out_wall_total (out_wall_total),
    .out_box_min_x  (out_box_min_x),
    .out_box_min_y  (out_box_min_y),
    .out_box_max_x  (out_box_max_x),
    .out_box_max_y  (out_box_max_y),
    .out_status     (dp_status)
  );

  // full-store flag is held by the sequencer for the whole result
  logic full_seen_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      full_seen_r <= add_full;
    end
  end

  assign out_status = full_seen_r ? ST_FULL : dp_status;

endmodule

/* hdl/wrc_datapath.sv */
// ----------------------------------------------------------------------------
// wrc_datapath
// Wall store, chain point, counters, bounding box and result register.
// ----------------------------------------------------------------------------
module wrc_datapath import wrc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               cfg_wr_en,
  input  logic [30:0]        cfg_wr_data,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_from_x,
  input  logic signed [31:0] in_from_y,
  input  logic signed [31:0] in_to_x,
  input  logic signed [31:0] in_to_y,
  output logic signed [31:0] out_cur_from_x,
  output logic signed [31:0] out_cur_from_y,
  output logic signed [31:0] out_cur_to_x,
  output logic signed [31:0] out_cur_to_y,
  output logic [5:0]         out_cursor_pos,
  output logic [6:0]         out_wall_total,
  output logic signed [31:0] out_box_min_x,
  output logic signed [31:0] out_box_min_y,
  output logic signed [31:0] out_box_max_x,
  output logic signed [31:0] out_box_max_y,
  output logic [1:0]         out_status
);

  wall_t              mem [MAX_WALLS];
  wall_t              rdata_r;
  wall_t              in_w_r, w_r;
  logic [1:0]         cmd_r;
  logic [30:0]        tol_r;
  logic [CW-1:0]      count_r, i_r, j_r;
  logic [AW-1:0]      cursor_r;
  logic               fwd_r;
  logic signed [31:0] px_r, py_r;
  logic signed [31:0] bminx_r, bminy_r, bmaxx_r, bmaxy_r;
  logic signed [31:0] ox_fx_r, ox_fy_r, ox_tx_r, ox_ty_r;
  logic signed [31:0] ob_mnx_r, ob_mny_r, ob_mxx_r, ob_mxy_r;
  logic [AW-1:0]      ocur_r;
  logic [CW-1:0]      ocnt_r;
  logic [1:0]         ostat_r;

  logic [AW-1:0]      rd_addr, wr_addr, cur_nxt;
  logic               wr_en;
  wall_t              wr_data;
  logic               hit_to, hit_from;
  logic [CW-1:0]      i_p1;

  assign i_p1     = i_r + CW'(1);
  assign hit_to   = near(px_r, rdata_r.tx, tol_r) && near(py_r, rdata_r.ty, tol_r);
  assign hit_from = near(px_r, rdata_r.fx, tol_r) && near(py_r, rdata_r.fy, tol_r);

  assign stat.cmd      = cmd_r;
  assign stat.full     = (count_r == CW'(MAX_WALLS));
  assign stat.i_lt_cnt = (i_r < count_r);
  assign stat.j_lt_cnt = (j_r < count_r);
  assign stat.j_gt_i1  = (j_r > i_p1);
  assign stat.match    = hit_to || hit_from;

  always_comb begin
    unique case (cmd.rd_src)
      RD_ZERO: rd_addr = '0;
      RD_J:    rd_addr = j_r[AW-1:0];
      RD_JM1:  rd_addr = j_r[AW-1:0] - AW'(1);
      RD_CUR:  rd_addr = cursor_r;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = cmd.do_add || cmd.wr_shift || cmd.wr_put;
    wr_addr = count_r[AW-1:0];
    wr_data = in_w_r;
    if (cmd.wr_shift) begin
      wr_addr = j_r[AW-1:0];
      wr_data = rdata_r;
    end else if (cmd.wr_put) begin
      wr_addr = i_p1[AW-1:0];
      wr_data = w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // cursor step, wraps at the fill count
  always_comb begin
    cur_nxt = cursor_r;
    if (count_r != '0) begin
      if (fwd_r) begin
        cur_nxt = ((CW'(cursor_r) + CW'(1)) >= count_r) ? '0 : cursor_r + AW'(1);
      end else begin
        cur_nxt = (cursor_r == '0) ? AW'(count_r - CW'(1)) : cursor_r - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= 31'd66;
      count_r  <= '0;
      cursor_r <= '0;
      fwd_r    <= 1'b0;
      bminx_r  <= 32'sh7FFFFFFF;
      bminy_r  <= 32'sh7FFFFFFF;
      bmaxx_r  <= 32'sh80000000;
      bmaxy_r  <= 32'sh80000000;
    end else begin
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
      if (cmd.do_add) begin
        count_r <= count_r + CW'(1);
        bminx_r <= (in_w_r.fx < bminx_r) ? ((in_w_r.tx < in_w_r.fx) ? in_w_r.tx : in_w_r.fx)
                 : ((in_w_r.tx < bminx_r) ? in_w_r.tx : bminx_r);
        bminy_r <= (in_w_r.fy < bminy_r) ? ((in_w_r.ty < in_w_r.fy) ? in_w_r.ty : in_w_r.fy)
                 : ((in_w_r.ty < bminy_r) ? in_w_r.ty : bminy_r);
        bmaxx_r <= (in_w_r.fx > bmaxx_r) ? ((in_w_r.tx > in_w_r.fx) ? in_w_r.tx : in_w_r.fx)
                 : ((in_w_r.tx > bmaxx_r) ? in_w_r.tx : bmaxx_r);
        bmaxy_r <= (in_w_r.fy > bmaxy_r) ? ((in_w_r.ty > in_w_r.fy) ? in_w_r.ty : in_w_r.fy)
                 : ((in_w_r.ty > bmaxy_r) ? in_w_r.ty : bmaxy_r);
      end
      if (cmd.step_cur) begin
        cursor_r <= cur_nxt;
      end
      if (cmd.flip_dir) begin
        fwd_r <= !fwd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r     <= in_cmd;
      in_w_r.fx <= in_from_x;
      in_w_r.fy <= in_from_y;
      in_w_r.tx <= in_to_x;
      in_w_r.ty <= in_to_y;
    end
    if (cmd.set_p) begin
      px_r <= rdata_r.tx;
      py_r <= rdata_r.ty;
      i_r  <= '0;
    end
    if (cmd.init_j) begin
      j_r <= i_p1;
    end else if (cmd.inc_j) begin
      j_r <= j_r + CW'(1);
    end else if (cmd.wr_shift) begin
      j_r <= j_r - CW'(1);
    end
    if (cmd.take_match) begin
      w_r  <= rdata_r;
      px_r <= hit_to ? rdata_r.fx : rdata_r.tx;
      py_r <= hit_to ? rdata_r.fy : rdata_r.ty;
    end
    if (cmd.wr_put || cmd.next_i) begin
      i_r <= i_p1;
    end
    if (cmd.load_out) begin
      ox_fx_r  <= (count_r != '0) ? rdata_r.fx : '0;
      ox_fy_r  <= (count_r != '0) ? rdata_r.fy : '0;
      ox_tx_r  <= (count_r != '0) ? rdata_r.tx : '0;
      ox_ty_r  <= (count_r != '0) ? rdata_r.ty : '0;
      ocur_r   <= cursor_r;
      ocnt_r   <= count_r;
      // box is held with the result so a later add cannot change it mid-wait
      ob_mnx_r <= bminx_r;
      ob_mny_r <= bminy_r;
      ob_mxx_r <= bmaxx_r;
      ob_mxy_r <= bmaxy_r;
      if (cmd_r == CMD_ADD) begin
        // a dropped add is flagged by the sequencer
        ostat_r <= ST_OK;
      end else begin
        ostat_r <= (count_r == '0) ? ST_EMPTY : ST_OK;
      end
    end
  end

  assign out_cur_from_x = ox_fx_r;
  assign out_cur_from_y = ox_fy_r;
  assign out_cur_to_x   = ox_tx_r;
  assign out_cur_to_y   = ox_ty_r;
  assign out_cursor_pos = 6'(ocur_r);
  assign out_wall_total = 7'(ocnt_r);
  assign out_box_min_x  = ob_mnx_r;
  assign out_box_min_y  = ob_mny_r;
  assign out_box_max_x  = ob_mxx_r;
  assign out_box_max_y  = ob_mxy_r;
  assign out_status     = ostat_r;

endmodule

/* hdl/wrc_ctrl.sv */
// ----------------------------------------------------------------------------
// wrc_ctrl
// Sequencer for add / re-chain / cursor commands and the result handshake.
// ----------------------------------------------------------------------------
`include "wall_ring_chainer_macros.svh"

module wrc_ctrl import wrc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     add_full
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_STEP2 = 4'd2;
  localparam logic [3:0] S_STEP1 = 4'd3;
  localparam logic [3:0] S_CH0   = 4'd4;
  localparam logic [3:0] S_CH1   = 4'd5;
  localparam logic [3:0] S_SRCH  = 4'd6;
  localparam logic [3:0] S_CMPRD = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_SHIFT = 4'd9;
  localparam logic [3:0] S_SHWR  = 4'd10;
  localparam logic [3:0] S_PUT   = 4'd11;
  localparam logic [3:0] S_RDCUR = 4'd12;
  localparam logic [3:0] S_RES   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       full_r, full_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign add_full  = full_r;

  always_comb begin
    state_nxt = state_r;
    full_nxt  = full_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        full_nxt = 1'b0;
        unique case (stat.cmd)
          CMD_ADD: begin
            if (stat.full) begin
              full_nxt  = 1'b1;
              state_nxt = S_RDCUR;
            end else begin
              cmd.do_add = 1'b1;
              state_nxt  = S_CH0;
            end
          end
          CMD_STEP: state_nxt = S_STEP1;
          CMD_REV: begin
            cmd.flip_dir = 1'b1;
            state_nxt    = S_STEP2;
          end
          default: state_nxt = S_RDCUR;
        endcase
      end
      S_STEP2: begin
        cmd.step_cur = 1'b1;
        state_nxt    = S_STEP1;
      end
      S_STEP1: begin
        cmd.step_cur = 1'b1;
        state_nxt    = S_RDCUR;
      end
      S_CH0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_ZERO;
        state_nxt  = S_CH1;
      end
      S_CH1: begin
        cmd.set_p = 1'b1;
        state_nxt = S_SRCH;
      end
      S_SRCH: begin
        if (!stat.i_lt_cnt) begin
          state_nxt = S_RDCUR;
        end else begin
          cmd.init_j = 1'b1;
          state_nxt  = S_CMPRD;
        end
      end
      S_CMPRD: begin
        if (!stat.j_lt_cnt) begin
          cmd.next_i = 1'b1;
          state_nxt  = S_SRCH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_J;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.match) begin
          cmd.take_match = 1'b1;
          state_nxt      = S_SHIFT;
        end else begin
          cmd.inc_j = 1'b1;
          state_nxt = S_CMPRD;
        end
      end
      S_SHIFT: begin
        if (stat.j_gt_i1) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_JM1;
          state_nxt  = S_SHWR;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_SHWR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_SHIFT;
      end
      S_PUT: begin
        cmd.wr_put = 1'b1;
        state_nxt  = S_SRCH;
      end
      S_RDCUR: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_CUR;
        state_nxt  = S_RES;
      end
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      full_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      full_r      <= full_nxt;
    end
  end

  `WRC_ASSERT(a_load_free, cmd.load_out |-> (!out_valid_r || out_ready), "result overwritten")
  `WRC_ASSERT(a_one_write, !(cmd.wr_shift && cmd.wr_put) && !(cmd.do_add && cmd.wr_put), "two writes")
  `WRC_ASSERT(a_match_shift, cmd.take_match |=> (state_r == S_SHIFT), "match not followed by shift")
  `WRC_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset not idle")

endmodule
